/* sv/hsr_pkg.sv */
package hsr_pkg;

  localparam int KEY_W       = 64;
  localparam int ACT_W       = 8;
  localparam int RATIO_W     = 16;
  localparam int TOTAL_W     = 40;
  localparam int REDIR_W     = 32;
  localparam int SHARD_OUT_W = 7;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SHARDS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOTSPOT_RATIO = 4'd1;

  localparam logic [ACT_W-1:0]   ACTIVE_RESET = 8'd16;
  localparam logic [RATIO_W-1:0] RATIO_RESET  = 16'd384;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [REDIR_W-1:0] REDIR_MAX = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD_HOME,
    ST_UPD_HOME,
    ST_MUL,
    ST_CMP,
    ST_SCAN,
    ST_RECALC,
    ST_FINISH
  } hsr_state_t;

  typedef struct packed {
    logic clear_step;
    logic load_key;
    logic div_step;
    logic rd_home;
    logic upd_home;
    logic mul;
    logic cmp;
    logic scan_step;
    logic sum_step;
    logic recalc_start;
    logic cfg_we;
    logic finish;
  } hsr_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_last;
    logic hot;
    logic walk_done;
  } hsr_status_t;

endpackage

/* sv/hsr_ram.sv */
module hsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/hsr_ctrl.sv */
module hsr_ctrl
  import hsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  hsr_status_t          status,
  output hsr_cmd_t             cmd
);

  hsr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = (state_r == ST_CLEAR) || (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.cfg_we = cfg_valid && cfg_ready;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == REG_ACTIVE_SHARDS) begin
            cmd.recalc_start = 1'b1;
            state_nxt        = ST_RECALC;
          end
        end else if (in_valid) begin
          cmd.load_key = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_RD_HOME;
        end
      end
      ST_RD_HOME: begin
        cmd.rd_home = 1'b1;
        state_nxt   = ST_UPD_HOME;
      end
      ST_UPD_HOME: begin
        cmd.upd_home = 1'b1;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = status.hot ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.walk_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_RECALC: begin
        cmd.sum_step = 1'b1;
        if (status.walk_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

/* sv/hsr_dpath.sv */
module hsr_dpath
  import hsr_pkg::*;
#(
  parameter int MAX_SHARDS  = 128,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hsr_cmd_t               cmd,
  output hsr_status_t            status,
  input  logic [KEY_W-1:0]       in_key,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [SHARD_OUT_W-1:0] out_shard,
  output logic [SHARD_OUT_W-1:0] out_home_shard,
  output logic                   out_redirected,
  output logic [REDIR_W-1:0]     out_redirect_total
);

  localparam int IW    = $clog2(MAX_SHARDS);
  localparam int NW    = IW + 1;
  localparam int CW    = COUNT_WIDTH;
  localparam int PW    = CW + NW;
  localparam int RW    = TOTAL_W + RATIO_W;
  localparam int CMPW  = (PW + 8 > RW) ? PW + 8 : RW;
  localparam int SUMW  = ((CW > TOTAL_W) ? CW : TOTAL_W) + 1;
  localparam int DCW   = $clog2(KEY_W);

  localparam logic [CW-1:0] COUNT_MAX = '1;

  logic [ACT_W-1:0]   active_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [REDIR_W-1:0] redir_cnt_r, redir_cnt_nxt;
  logic [IW-1:0]      clr_cnt_r;

  logic [KEY_W-1:0]   key_r;
  logic [IW-1:0]      rem_r;
  logic [DCW-1:0]     div_cnt_r;
  logic [CW-1:0]      load_r;
  logic [PW-1:0]      prod_r;
  logic [RW-1:0]      rhs_r;
  logic               hot_r;
  logic [NW-1:0]      walk_cnt_r;
  logic [CW-1:0]      best_r;
  logic [IW-1:0]      best_idx_r;

  logic [SHARD_OUT_W-1:0] shard_r, home_r;
  logic                   redir_r;
  logic [REDIR_W-1:0]     total_out_r;

  logic [15:0]   act_ext, eff_ext;
  logic [NW-1:0] eff_n;
  logic [IW:0]   rem2, rem2_nxt;
  logic          hot_w;
  logic [NW-1:0] walk_prev;
  logic          redir_w;
  logic [IW+6:0] tgt_ext, home_ext;
  logic [SUMW-1:0] sum_w;
  logic [TOTAL_W-1:0] sum_base;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;

  hsr_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_SHARDS)
  ) u_loads (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective shard count: zero acts as one, clamp at MAX_SHARDS
  assign act_ext = {8'b0, active_r};
  assign eff_ext = (act_ext == 16'd0) ? 16'd1 :
                   (act_ext > 16'(MAX_SHARDS)) ? 16'(MAX_SHARDS) : act_ext;
  assign eff_n   = eff_ext[NW-1:0];

  // restoring divider, one key bit per cycle
  assign rem2     = {rem_r, key_r[KEY_W-1]};
  assign rem2_nxt = (rem2 >= eff_n) ? (rem2 - eff_n) : rem2;

  assign hot_w = (total_r != '0) &&
                 (CMPW'({prod_r, 8'b0}) > CMPW'(rhs_r));

  assign walk_prev = walk_cnt_r - 1'b1;

  assign sum_base = (walk_cnt_r == NW'(1)) ? '0 : total_r;
  assign sum_w    = SUMW'(sum_base) + SUMW'(ram_rdata);

  assign status.clear_done = (clr_cnt_r == IW'(MAX_SHARDS - 1));
  assign status.div_last   = (div_cnt_r == DCW'(KEY_W - 1));
  assign status.hot        = hot_w;
  assign status.walk_done  = (walk_cnt_r == eff_n);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rem_r;
    ram_wdata = ram_rdata + 1'b1;
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (cmd.upd_home) begin
      ram_we = (ram_rdata != COUNT_MAX);
    end
    ram_raddr = cmd.rd_home ? rem_r : walk_cnt_r[IW-1:0];
  end

  always_comb begin
    total_nxt = total_r;
    if (cmd.upd_home) begin
      if (ram_rdata != COUNT_MAX && total_r != TOTAL_MAX) begin
        total_nxt = total_r + 1'b1;
      end
    end else if (cmd.sum_step && walk_cnt_r != '0) begin
      total_nxt = (sum_w > SUMW'(TOTAL_MAX)) ? TOTAL_MAX : sum_w[TOTAL_W-1:0];
    end
  end

  assign redir_w       = hot_r && (best_idx_r != rem_r);
  assign redir_cnt_nxt = (redir_w && redir_cnt_r != REDIR_MAX) ?
                         redir_cnt_r + 1'b1 : redir_cnt_r;
  assign tgt_ext  = {{SHARD_OUT_W{1'b0}}, (redir_w ? best_idx_r : rem_r)};
  assign home_ext = {{SHARD_OUT_W{1'b0}}, rem_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACTIVE_RESET;
      ratio_r     <= RATIO_RESET;
      total_r     <= '0;
      redir_cnt_r <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cmd.cfg_we) begin
        if (cfg_index == REG_ACTIVE_SHARDS) begin
          active_r <= cfg_data[ACT_W-1:0];
        end else if (cfg_index == REG_HOTSPOT_RATIO) begin
          ratio_r <= cfg_data;
        end
      end
      total_r <= total_nxt;
      if (cmd.finish) begin
        redir_cnt_r <= redir_cnt_nxt;
      end
      if (cmd.clear_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r     <= in_key;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      key_r     <= {key_r[KEY_W-2:0], 1'b0};
      rem_r     <= rem2_nxt[IW-1:0];
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.upd_home) begin
      load_r <= (ram_rdata != COUNT_MAX) ? ram_rdata + 1'b1 : ram_rdata;
    end
    if (cmd.mul) begin
      prod_r <= PW'(load_r) * PW'(eff_n);
      rhs_r  <= RW'(total_r) * RW'(ratio_r);
    end
    if (cmd.cmp) begin
      hot_r <= hot_w;
    end
    if (cmd.cmp || cmd.recalc_start) begin
      walk_cnt_r <= '0;
    end else if (cmd.scan_step || cmd.sum_step) begin
      walk_cnt_r <= walk_cnt_r + 1'b1;
    end
    if (cmd.scan_step && walk_cnt_r != '0) begin
      if (walk_cnt_r == NW'(1) || ram_rdata < best_r) begin
        best_r     <= ram_rdata;
        best_idx_r <= walk_prev[IW-1:0];
      end
    end
    if (cmd.finish) begin
      shard_r     <= tgt_ext[SHARD_OUT_W-1:0];
      home_r      <= home_ext[SHARD_OUT_W-1:0];
      redir_r     <= redir_w;
      total_out_r <= redir_cnt_nxt;
    end
  end

  assign out_shard          = shard_r;
  assign out_home_shard     = home_r;
  assign out_redirected     = redir_r;
  assign out_redirect_total = total_out_r;

endmodule

/* sv/hotspot_aware_shard_router.sv */
// Channel   Handshake               Payload
// in_       in_valid / in_ready     in_key[63:0]
// out_      out_valid / out_ready   out_shard, out_home_shard, out_redirected,
//                                   out_redirect_total
// cfg_      cfg_valid / cfg_ready   cfg_index (0 active_shards, 1 hotspot_ratio_q8),
//                                   cfg_data
//
// After acceptance a key runs a bit-serial modulo, load read, update, multiply and
// compare; with a hot home shard a least-loaded scan of the load RAM over the N
// effective shards follows, and the output load comes last. The next key is accepted
// after the output load. After reset a pass zeroes the load RAM with in_ready low
// while cfg writes are taken. A write of active_shards re-sums the active loads.
// A finished result waits in the output register, so the next transaction still enters.
module hotspot_aware_shard_router
  import hsr_pkg::*;
#(
  parameter int MAX_SHARDS  = 128,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [KEY_W-1:0]       in_key,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SHARD_OUT_W-1:0] out_shard,
  output logic [SHARD_OUT_W-1:0] out_home_shard,
  output logic                   out_redirected,
  output logic [REDIR_W-1:0]     out_redirect_total,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  hsr_cmd_t    cmd;
  hsr_status_t status;

  // sequencing: clear, divide, update home load, hotspot test, scan, deliver
  hsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .status    (status),
    .cmd       (cmd)
  );

  // load RAM, totals, divider, multipliers and output register
  hsr_dpath #(
    .MAX_SHARDS  (MAX_SHARDS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_key             (in_key),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_shard          (out_shard),
    .out_home_shard     (out_home_shard),
    .out_redirected     (out_redirected),
    .out_redirect_total (out_redirect_total)
  );

  // an accepted transaction keeps the input side busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a transaction");

  // with MAX_SHARDS at most 128, a redirect always lands on a shard other than home
  a_redirect_differs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_redirected |-> (MAX_SHARDS > 128) || out_shard != out_home_shard)
    else $error("redirected to the home shard");

  // a redirect is always counted
  a_redirect_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_redirected |-> out_redirect_total != '0)
    else $error("redirect without a nonzero redirect total");

  // input and configuration never complete in the same cycle
  a_cfg_in_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !(cfg_valid && cfg_ready))
    else $error("input and configuration accepted together");

endmodule

/* tb/tb_hotspot_aware_shard_router.sv */
`timescale 1ns / 100ps

module tb_hotspot_aware_shard_router;
  import hsr_pkg::*;

  localparam int SHARD_LIMIT = 128;
  localparam int LOAD_W      = 32;
  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
  // Writes to this index must leave both registers alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;
  // Receiver hold-off used to back the block up into its input.
  localparam int LONG_HOLD = 600;
  // Give the tail some margin over the slowest result, a hot key with a full scan.
  localparam int TAIL_CYCLES = 260;
  localparam int RANDOM_PHASES = 19;
  localparam int PHASE_KEYS = 100;

  // One expected routing decision, with the key kept for the report.
  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [SHARD_OUT_W-1:0] shard;
    logic [SHARD_OUT_W-1:0] home;
    logic                   redirected;
    logic [REDIR_W-1:0]     total;
  } route_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [KEY_W-1:0]       in_key;
  logic                   out_valid;
  logic                   out_ready;
  logic [SHARD_OUT_W-1:0] out_shard;
  logic [SHARD_OUT_W-1:0] out_home_shard;
  logic                   out_redirected;
  logic [REDIR_W-1:0]     out_redirect_total;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Mirror of the router state.
  logic [LOAD_W-1:0]  shard_load [SHARD_LIMIT];
  logic [TOTAL_W-1:0] load_sum;
  logic [REDIR_W-1:0] redirect_tally;
  logic [ACT_W-1:0]   act_shards;
  logic [RATIO_W-1:0] hot_ratio;

  route_t pending_routes[$];

  int unsigned mismatch_count;
  int unsigned keys_sent;
  int unsigned results_seen;
  int unsigned redirect_hits;
  int unsigned reg_writes;
  int unsigned long_holds;
  int unsigned in_gap_max;
  int unsigned out_gap_max;
  logic        long_hold;

  hotspot_aware_shard_router #(
    .MAX_SHARDS (SHARD_LIMIT),
    .COUNT_WIDTH(LOAD_W)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_shard         (out_shard),
    .out_home_shard    (out_home_shard),
    .out_redirected    (out_redirected),
    .out_redirect_total(out_redirect_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Router mirror
  // ---------------------------------------------------------------------------

  // Clamp the programmed shard count: zero acts as one, too many acts as the limit.
  function automatic int unsigned live_shards();
    if (act_shards == '0) return 1;
    if (act_shards > SHARD_LIMIT) return SHARD_LIMIT;
    return act_shards;
  endfunction

  task automatic clear_mirror();
    foreach (shard_load[i]) shard_load[i] = '0;
    load_sum       = '0;
    redirect_tally = '0;
    act_shards     = ACTIVE_RESET;
    hot_ratio      = RATIO_RESET;
  endtask

  // Rebuild the running total from the loads of the shards now in use.
  task automatic resum_loads();
    longint unsigned acc;
    int unsigned     n;
    acc = 0;
    n   = live_shards();
    for (int unsigned i = 0; i < n; i++) begin
      acc += shard_load[i];
      if (acc > TOTAL_MAX) acc = TOTAL_MAX;
    end
    load_sum = acc[TOTAL_W-1:0];
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ACTIVE_SHARDS: begin
        act_shards = data[ACT_W-1:0];
        resum_loads();
      end
      REG_HOTSPOT_RATIO: hot_ratio = data[RATIO_W-1:0];
      default: ;
    endcase
  endtask

  // Route one key: bump the home load, then run the hotspot test and the
  // least-loaded search. The home load is the one that grows, even on redirect.
  task automatic predict_route(input logic [KEY_W-1:0] key);
    int unsigned       n;
    int unsigned       home;
    int unsigned       target;
    logic [LOAD_W-1:0] best;
    logic [63:0]       lhs;
    logic [63:0]       rhs;
    route_t            r;
    n    = live_shards();
    home = key % 64'(n);
    if (shard_load[home] != LOAD_MAX) begin
      shard_load[home]++;
      if (load_sum != TOTAL_MAX) load_sum++;
    end
    lhs          = 64'(shard_load[home]) * 64'(n) * 64'd256;
    rhs          = 64'(load_sum) * 64'(hot_ratio);
    target       = home;
    r.redirected = 1'b0;
    if (load_sum != '0 && lhs > rhs) begin
      target = 0;
      best   = shard_load[0];
      for (int unsigned i = 1; i < n; i++) begin
        if (shard_load[i] < best) begin
          best   = shard_load[i];
          target = i;
        end
      end
      if (target != home) begin
        r.redirected = 1'b1;
        if (redirect_tally != REDIR_MAX) redirect_tally++;
      end else begin
        target = home;
      end
    end
    r.key   = key;
    r.shard = target[SHARD_OUT_W-1:0];
    r.home  = home[SHARD_OUT_W-1:0];
    r.total = redirect_tally;
    pending_routes.insert(pending_routes.size(), r);
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers. Inputs move on the falling edge, handshakes are seen on
  // the rising edge.
  // ---------------------------------------------------------------------------

  // Offer one key after a random gap; valid stays up into the next call when
  // that call draws no gap.
  task automatic send_key(input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_key   <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_route(key);
    keys_sent++;
  endtask

  task automatic in_rest();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Only called with no key in flight; the write still waits for cfg_ready.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait until every routed key has come back.
  task automatic wait_drained();
    in_rest();
    while (pending_routes.size() != 0) @(posedge clk);
  endtask

  // Receiver: draw a stall per result, or take the long hold when requested.
  initial begin : result_sink
    int unsigned wait_n;
    out_ready = 1'b0;
    forever begin
      if (long_hold) begin
        wait_n    = LONG_HOLD;
        long_hold = 1'b0;
        long_holds++;
      end else begin
        wait_n = $urandom_range(0, out_gap_max);
      end
      @(negedge clk);
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want, input logic [KEY_W-1:0] key);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, want %0d (key %h)",
             $realtime, field, got, want, key);
  endtask

  // Compare every accepted result with the oldest routing decision.
  always @(posedge clk) begin : route_check
    route_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_redirected) redirect_hits++;
      if (pending_routes.size() == 0) begin
        report_mismatch("unexpected result, shard", 64'(out_shard), '0, '0);
      end else begin
        want = pending_routes.pop_front();
        if (out_shard !== want.shard)
          report_mismatch("shard", 64'(out_shard), 64'(want.shard), want.key);
        if (out_home_shard !== want.home)
          report_mismatch("home_shard", 64'(out_home_shard), 64'(want.home), want.key);
        if (out_redirected !== want.redirected)
          report_mismatch("redirected", 64'(out_redirected), 64'(want.redirected),
                          want.key);
        if (out_redirect_total !== want.total)
          report_mismatch("redirect_total", 64'(out_redirect_total), 64'(want.total),
                          want.key);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: 16 shards, ratio 1.5. Keys at both ends of the range.
  task automatic test_reset_defaults();
    send_key('0);
    send_key('1);
    send_key(64'd21);
    wait_drained();
  endtask

  // Zero shards acts as one; anything above the limit acts as the limit.
  task automatic test_shard_count_edges();
    write_reg(REG_ACTIVE_SHARDS, 16'h0000);
    send_key('1);
    wait_drained();
    // High byte of the data is ignored; 255 clamps to 128.
    write_reg(REG_ACTIVE_SHARDS, 16'hFFFF);
    send_key('1);
    send_key(64'd128);
    wait_drained();
    write_reg(REG_ACTIVE_SHARDS, 16'd128);
    send_key(64'h8000_0000_0000_007F);
    wait_drained();
  endtask

  // Hammer one home shard until it trips the threshold, then try a ratio of
  // zero (every key scans) and the largest ratio (nothing is hot).
  task automatic test_hotspot_redirect();
    write_reg(REG_ACTIVE_SHARDS, 16'd3);
    write_reg(REG_HOTSPOT_RATIO, 16'd256);
    repeat (4) send_key(64'd1);
    wait_drained();
    write_reg(REG_HOTSPOT_RATIO, 16'd0);
    send_key(64'd0);
    send_key(64'd1);
    send_key(64'd2);
    wait_drained();
    write_reg(REG_HOTSPOT_RATIO, 16'hFFFF);
    send_key(64'd5);
    wait_drained();
  endtask

  // Shrinking and growing the shard count rebuilds the total from kept loads;
  // the loads of regrown shards are kept from before rather than reset to zero.
  task automatic test_shard_count_change();
    write_reg(REG_HOTSPOT_RATIO, RATIO_RESET);
    write_reg(REG_ACTIVE_SHARDS, 16'd2);
    send_key(64'd3);
    wait_drained();
    write_reg(REG_ACTIVE_SHARDS, 16'd6);
    write_reg(REG_SPARE, 16'hFFFF);
    send_key(64'd4);
    wait_drained();
  endtask

  // Hold the receiver off long enough that the block stops taking keys.
  task automatic test_output_backpressure();
    write_reg(REG_ACTIVE_SHARDS, 16'd4);
    in_gap_max = 0;
    long_hold  = 1'b1;
    repeat (12) send_key({$urandom, $urandom});
    wait_drained();
  endtask

  // Phases of random keys, each with its own shard count, ratio and idling.
  // Most keys pile onto one hot shard so redirects keep happening.
  task automatic test_random_traffic();
    logic [ACT_W-1:0]   act;
    logic [RATIO_W-1:0] ratio;
    logic [KEY_W-1:0]   key;
    int unsigned        n;
    int unsigned        hot;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // Keep most phases small; only a few pay for the full 128-shard scan.
      if (p == 5) act = 8'd128;
      else if (p == 11) act = 8'd255;
      else if (p == 14) act = 8'd0;
      else if (p == 17) act = 8'($urandom_range(17, 127));
      else act = 8'($urandom_range(1, 16));
      case ($urandom_range(0, 5))
        0:       ratio = 16'd256;
        1:       ratio = RATIO_RESET;
        2:       ratio = 16'hFFFF;
        3:       ratio = 16'($urandom_range(0, 255));
        default: ratio = 16'($urandom_range(256, 1024));
      endcase
      write_reg(REG_ACTIVE_SHARDS, {8'($urandom), act});
      write_reg(REG_HOTSPOT_RATIO, ratio);
      // Some phases run flat out on both sides.
      in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 16;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
      n   = live_shards();
      hot = $urandom_range(0, n - 1);
      for (int k = 0; k < PHASE_KEYS; k++) begin
        if ($urandom_range(0, 19) == 0) hot = $urandom_range(0, n - 1);
        if ($urandom_range(0, 9) < 6)
          key = 64'(n) * ({$urandom, $urandom} >> 7) + 64'(hot);
        else
          key = {$urandom, $urandom};
        send_key(key);
      end
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_key         = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    long_hold      = 1'b0;
    in_gap_max     = 3;
    out_gap_max    = 3;
    mismatch_count = 0;
    keys_sent      = 0;
    results_seen   = 0;
    redirect_hits  = 0;
    reg_writes     = 0;
    long_holds     = 0;
    clear_mirror();

    // Hold reset, then release it on a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_shard_count_edges();
    test_hotspot_redirect();
    test_shard_count_change();
    test_output_backpressure();
    test_random_traffic();

    // Let any stray result show up before deciding.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d keys, %0d results, %0d redirected, %0d register writes",
             keys_sent, results_seen, redirect_hits, reg_writes);
    $display("shard counts 0 to 255 (clamped 1..128), ratios 0 to 65535, %0d long stall(s)",
             long_holds);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #20ms;
    $display("timeout with %0d result(s) outstanding", pending_routes.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
